@@ design/distance_vector_route_node_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the distance-vector route node.
// Define ASSERT_OFF to compile every assertion away.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_NODE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_NODE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define DVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvr assertion failed");

`else

`define DVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/dvr_pkg.sv @@
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared widths, codes, control types and saturating cost arithmetic.
// ----------------------------------------------------------------------------
package dvr_pkg;

  localparam int NODES      = 4;
  localparam int NODE_W     = $clog2(NODES);
  localparam int COST_W     = 10;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COST_W;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [NODES-1:0][COST_W-1:0] row_t;

  localparam cost_t INF_COST = COST_W'(999);

  // Link costs after reset, one per node.
  localparam cost_t LINK_RESET [NODES] = '{COST_W'(1), COST_W'(0), COST_W'(1), COST_W'(999)};
  localparam node_t SELF_RESET = NODE_W'(1);
  localparam logic [NODES-1:0] MASK_RESET = NODES'(5);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADV  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LINK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINK_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SELF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic  cap;
    logic  rd_en;
    logic  rd_peer;
    node_t rd_row;
    logic  ld_diag;
    logic  clr_chg;
    logic  wr_en;
    node_t wr_row;
    logic  pkt_load;
    node_t pkt_dest;
    logic  pkt_last;
  } dvr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd_code;
    logic             changed_any;
    logic [NODES-1:0] elig;
  } dvr_sts_t;

  function automatic cost_t sat(input cost_t v);
    return (v >= INF_COST) ? INF_COST : v;
  endfunction

  function automatic cost_t sat_add(input cost_t a, input cost_t b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a >= INF_COST || b >= INF_COST || s >= {1'b0, INF_COST}) begin
      return INF_COST;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

@@ design/dvr_if.sv @@
// ----------------------------------------------------------------------------
// dvr_in_if / dvr_out_if
// Valid/ready channels for command words and advertisement words.
// ----------------------------------------------------------------------------
interface dvr_in_if import dvr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  node_t            peer_node;
  cost_t            adv_cost_0;
  cost_t            adv_cost_1;
  cost_t            adv_cost_2;
  cost_t            adv_cost_3;
  cost_t            new_link_cost;

  modport source (output valid, command, peer_node, adv_cost_0, adv_cost_1, adv_cost_2,
                  adv_cost_3, new_link_cost, input ready);
  modport sink (input valid, command, peer_node, adv_cost_0, adv_cost_1, adv_cost_2,
                adv_cost_3, new_link_cost, output ready);
endinterface

interface dvr_out_if import dvr_pkg::*; ();
  logic  valid;
  logic  ready;
  node_t dest_node;
  cost_t min_cost_0;
  cost_t min_cost_1;
  cost_t min_cost_2;
  cost_t min_cost_3;
  logic  last;

  modport source (output valid, dest_node, min_cost_0, min_cost_1, min_cost_2, min_cost_3,
                  last, input ready);
  modport sink (input valid, dest_node, min_cost_0, min_cost_1, min_cost_2, min_cost_3,
                last, output ready);
endinterface

@@ design/dvr_dp.sv @@
// ----------------------------------------------------------------------------
// dvr_dp
// Configuration registers, cost table row memory, row update and minimum
// logic, best-cost vector and the output word register.
// ----------------------------------------------------------------------------
module dvr_dp import dvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      in_command,
  input  node_t                 in_peer_node,
  input  row_t                  in_adv_cost,
  input  cost_t                 in_new_link_cost,
  input  dvr_cmd_t              cmd,
  output dvr_sts_t              sts,
  output node_t                 out_dest_node,
  output row_t                  out_min_cost,
  output logic                  out_last
);

  cost_t            link_r [NODES];
  node_t            self_r;
  logic [NODES-1:0] mask_r;

  logic [CMD_W-1:0] cmd_r;
  node_t            peer_r;
  row_t             adv_r;
  cost_t            nc_r;
  cost_t            diag_r;
  logic             chg_r;
  cost_t            best_r [NODES];

  row_t             mem [NODES];
  logic [NODES-1:0] row_vld_r;
  row_t             rd_data_r;
  logic             rd_vld_r;
  node_t            rd_addr;

  node_t            dest_r;
  row_t             min_r;
  logic             last_r;

  row_t             row_cur;
  row_t             row_new;
  cost_t            peer_new;
  cost_t            old_e;
  cost_t            diff;
  cost_t            row_min;
  node_t            d;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        link_r[i] <= LINK_RESET[i];
      end
      self_r <= SELF_RESET;
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [REG_LINK_0:REG_LINK_3]: link_r[cfg_index[NODE_W-1:0]] <= cfg_data[COST_W-1:0];
        REG_SELF:                self_r <= cfg_data[NODE_W-1:0];
        REG_MASK:                mask_r <= cfg_data[NODES-1:0];
        default:                 ;
      endcase
    end
  end

  // Command word capture.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r  <= in_command;
      peer_r <= in_peer_node;
      adv_r  <= in_adv_cost;
      nc_r   <= in_new_link_cost;
    end
  end

  // Row memory with registered read; rows never written read as infinity.
  assign rd_addr = cmd.rd_peer ? peer_r : cmd.rd_row;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_row] <= row_new;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        row_vld_r[cmd.wr_row] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign row_cur = rd_vld_r ? rd_data_r : {NODES{INF_COST}};
  assign d       = cmd.wr_row;

  // New value of the entry in the peer's column of row d.
  always_comb begin
    old_e    = row_cur[peer_r];
    diff     = (old_e > diag_r) ? cost_t'(old_e - diag_r) : '0;
    peer_new = old_e;
    if (cmd_r == CMD_ADV) begin
      peer_new = sat_add(diag_r, adv_r[d]);
    end else if (d == peer_r) begin
      peer_new = sat(nc_r);
    end else if (old_e >= INF_COST) begin
      peer_new = INF_COST;
    end else begin
      peer_new = sat_add(nc_r, diff);
    end
  end

  always_comb begin
    for (int v = 0; v < NODES; v++) begin
      if (cmd_r == CMD_INIT) begin
        row_new[v] = (node_t'(v) == d) ? sat(link_r[d]) : INF_COST;
      end else if ((cmd_r == CMD_ADV || cmd_r == CMD_LINK) && node_t'(v) == peer_r) begin
        row_new[v] = peer_new;
      end else begin
        row_new[v] = row_cur[v];
      end
    end
    row_min = INF_COST;
    for (int v = 0; v < NODES; v++) begin
      if (row_new[v] < row_min) begin
        row_min = row_new[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_diag) begin
      diag_r <= row_cur[peer_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        best_r[i] <= INF_COST;
      end
      chg_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        best_r[d] <= row_min;
      end
      if (cmd.clr_chg) begin
        chg_r <= 1'b0;
      end else if (cmd.wr_en) begin
        chg_r <= chg_r | (row_min != best_r[d]);
      end
    end
  end

  assign sts.cmd_code    = cmd_r;
  assign sts.changed_any = chg_r | (row_min != best_r[d]);
  assign sts.elig        = mask_r & ~(NODES'(1) << self_r);

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.pkt_load) begin
      dest_r <= cmd.pkt_dest;
      last_r <= cmd.pkt_last;
      for (int i = 0; i < NODES; i++) begin
        min_r[i] <= best_r[i];
      end
    end
  end

  assign out_dest_node = dest_r;
  assign out_min_cost  = min_r;
  assign out_last      = last_r;

endmodule

@@ design/dvr_ctrl.sv @@
// ----------------------------------------------------------------------------
// dvr_ctrl
// Sequencer: diagonal fetch, row sweep over the cost table, and the
// advertisement run with output valid handling.
// ----------------------------------------------------------------------------
`include "distance_vector_route_node_macros.svh"

module dvr_ctrl import dvr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output dvr_cmd_t         cmd,
  input  dvr_sts_t         sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDDIAG = 3'd1;
  localparam logic [2:0] S_LDDIAG = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  node_t            cnt_r, cnt_nxt;
  logic [NODES-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  node_t            pick;
  logic [NODES-1:0] rem_left;

  // Lowest remaining destination goes out first.
  always_comb begin
    pick = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        pick = node_t'(i);
      end
    end
    rem_left = rem_r & ~(NODES'(1) << pick);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (in_command != CMD_NONE) begin
            state_nxt = S_RDDIAG;
          end
        end
      end
      S_RDDIAG: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_peer = 1'b1;
        state_nxt   = S_LDDIAG;
      end
      S_LDDIAG: begin
        cmd.ld_diag = 1'b1;
        cmd.clr_chg = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_row  = '0;
        cnt_nxt     = '0;
        state_nxt   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_row = cnt_r;
        cmd.rd_en  = 1'b1;
        cmd.rd_row = cnt_r + 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == node_t'(NODES - 1)) begin
          rem_nxt = sts.elig;
          if (sts.cmd_code == CMD_INIT || sts.changed_any) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.pkt_load = 1'b1;
          cmd.pkt_dest = pick;
          cmd.pkt_last = (rem_left == '0);
          rem_nxt      = rem_left;
          if (rem_left == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.pkt_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `DVR_ASSERT_NXT(a_last_ends_run, clk, rst_n, cmd.pkt_load && cmd.pkt_last, state_r == S_IDLE)
  `DVR_ASSERT_IMP(a_dest_pending, clk, rst_n, cmd.pkt_load, rem_r[cmd.pkt_dest])
  `DVR_ASSERT_NXT(a_sweep_exit, clk, rst_n, state_r == S_SWEEP && cnt_r == node_t'(NODES - 1), state_r == S_IDLE || state_r == S_EMIT)

endmodule

@@ design/distance_vector_route_node.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_node: one router of a distance-vector network.
// The diagonal is fetched and the rows are swept after the accept; advertisement
// words then go out one per cycle while the receiver keeps ready high. A new
// command word is taken only once the node is idle again after the previous one.
// Reset: synchronous, active low; table and minima read as infinity (999).
// ----------------------------------------------------------------------------
//
// The cost table (destination by via-neighbor) lives in a four-row memory,
// one row per destination, each row holding the four via costs. Every row
// carries a valid bit cleared by reset, so a row not yet written reads as all
// infinity and no clearing pass is needed.
//
// Processing a command word runs as follows:
//   1. The word is captured and the peer's row is read.
//   2. The peer's diagonal entry is latched; the read of row 0 is issued.
//   3. One row per cycle is rewritten: the peer's column entry is replaced
//      (init instead rebuilds the whole row from the link costs), the row
//      minimum is formed and stored in the best-cost vector, and a sticky
//      flag records any change. The next row is read in the same cycle.
//   4. After init, or when any minimum changed, one word per neighbor in the
//      mask (self excluded) goes out in ascending node order; the final word
//      carries last.
// The output word sits in its own register, so the controller can release
// the input side while the final advertisement still waits to be taken.
// The unused command code is accepted and dropped.
//
// Configuration writes are registered at once; registers are to be written only
// while the node is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module distance_vector_route_node import dvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dvr_in_if.sink                in_chan,
  dvr_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dvr_cmd_t cmd;
  dvr_sts_t sts;
  row_t     adv_cost;
  row_t     min_cost;

  // Advertised costs are handled as one packed row, entry i for node i.
  assign adv_cost = {in_chan.adv_cost_3, in_chan.adv_cost_2,
                     in_chan.adv_cost_1, in_chan.adv_cost_0};

  dvr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .cmd        (cmd),
    .sts        (sts)
  );

  dvr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_chan.command),
    .in_peer_node     (in_chan.peer_node),
    .in_adv_cost      (adv_cost),
    .in_new_link_cost (in_chan.new_link_cost),
    .cmd              (cmd),
    .sts              (sts),
    .out_dest_node    (out_chan.dest_node),
    .out_min_cost     (min_cost),
    .out_last         (out_chan.last)
  );

  assign out_chan.min_cost_0 = min_cost[0];
  assign out_chan.min_cost_1 = min_cost[1];
  assign out_chan.min_cost_2 = min_cost[2];
  assign out_chan.min_cost_3 = min_cost[3];

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the distance-vector route node
// Drives command words into the node under randomized back-pressure, keeps a
// cycle-free model of the cost table and the best-cost vector, and checks
// every advertisement word against it in order. A short directed table comes
// first. Random phases with different link costs, node ids and neighbor masks
// follow.
// ----------------------------------------------------------------------------
module testbench;
  import dvr_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int QUIET_CYCLES    = 16;
  localparam int DRAIN_CYCLES    = 24;
  localparam int STALL_LIMIT     = 2000; // cycles without any handshake
  localparam int REPORT_LIMIT    = 10;
  localparam int HOLD_CYCLES     = 200;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 40;

  localparam cost_t COST_MAX = '1;       // all ones, above infinity

  // One command word as the sender sees it. adv[d] is the advertised cost
  // to node d.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    node_t            peer;
    row_t             adv;
    cost_t            new_link;
  } command_word_t;

  // One advertisement word as the node should send it.
  typedef struct packed {
    node_t dest;
    row_t  mins;
    logic  last;
  } advert_t;

  // A row of the directed table: either a register write or a command word.
  // Rows with typed set carry the best costs that are plain to see.
  typedef struct {
    bit                    is_write;
    command_word_t         word;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    bit                    typed;
    row_t                  typed_mins;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dvr_in_if  in_if ();
  dvr_out_if out_if ();

  distance_vector_route_node DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if.sink),
    .out_chan  (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state. route_table is indexed [destination][via neighbor].
  cost_t            route_table [NODES][NODES];
  cost_t            best_vec    [NODES];
  cost_t            link_reg    [NODES];
  node_t            self_reg;
  logic [NODES-1:0] mask_reg;

  advert_t   adv_expected  [$];
  plan_row_t directed_plan [$];

  int tx_idle_pct   = 13;
  int rx_idle_pct   = 86;
  int hold_request  = 0;
  int error_count   = 0;
  int stall_count   = 0;

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the node
  // --------------------------------------------------------------------------

  // Every value at or above infinity counts as infinity.
  function automatic cost_t clamp_cost(input int unsigned v);
    return (v >= INF_COST) ? INF_COST : cost_t'(v);
  endfunction

  function automatic cost_t add_clamped(input cost_t a, input cost_t b);
    int unsigned s;
    if (a >= INF_COST || b >= INF_COST) begin
      return INF_COST;
    end
    s = 32'(a) + 32'(b);
    return clamp_cost(s);
  endfunction

  // Rebuilds the best-cost vector from the table rows and tells whether any
  // entry moved.
  function automatic bit refresh_minima();
    bit    moved;
    cost_t m;
    moved = 1'b0;
    for (int d = 0; d < NODES; d++) begin
      m = INF_COST;
      for (int v = 0; v < NODES; v++) begin
        if (route_table[d][v] < m) begin
          m = route_table[d][v];
        end
      end
      if (m != best_vec[d]) begin
        moved = 1'b1;
      end
      best_vec[d] = m;
    end
    return moved;
  endfunction

  // Applies one accepted command word to the model and queues the
  // advertisement run it causes, one word per neighbor in ascending order.
  function automatic void apply_command(input command_word_t w, input bit typed,
                                        input row_t typed_mins);
    cost_t   diag;
    cost_t   e;
    bit      send;
    advert_t run [$];
    advert_t a;
    send = 1'b0;
    diag = route_table[w.peer][w.peer];
    case (w.command)
      CMD_INIT: begin
        for (int d = 0; d < NODES; d++) begin
          for (int v = 0; v < NODES; v++) begin
            route_table[d][v] = (d == v) ? clamp_cost(32'(link_reg[d])) : INF_COST;
          end
        end
        void'(refresh_minima());
        send = 1'b1;
      end
      CMD_ADV: begin
        // The column becomes the link cost to the peer plus what it offers.
        for (int d = 0; d < NODES; d++) begin
          route_table[d][w.peer] = add_clamped(diag, w.adv[d]);
        end
        send = refresh_minima();
      end
      CMD_LINK: begin
        // The column moves by the cost difference. Infinite entries stay put,
        // and an entry at or below the old diagonal is moved to the new cost.
        for (int d = 0; d < NODES; d++) begin
          e = route_table[d][w.peer];
          if (d == w.peer) begin
            route_table[d][w.peer] = clamp_cost(32'(w.new_link));
          end else if (e >= INF_COST) begin
            route_table[d][w.peer] = INF_COST;
          end else begin
            route_table[d][w.peer] =
              add_clamped(w.new_link, (e > diag) ? cost_t'(e - diag) : cost_t'(0));
          end
        end
        send = refresh_minima();
      end
      default: begin
        // The unused code leaves everything as it was.
        send = 1'b0;
      end
    endcase
    if (send) begin
      for (int n = 0; n < NODES; n++) begin
        if (n != self_reg && mask_reg[n]) begin
          a.dest = node_t'(n);
          for (int d = 0; d < NODES; d++) begin
            a.mins[d] = typed ? typed_mins[d] : best_vec[d];
          end
          a.last = 1'b0;
          run.push_back(a);
        end
      end
      if (run.size() > 0) begin
        run[run.size()-1].last = 1'b1;
      end
      foreach (run[i]) begin
        adv_expected.push_back(run[i]);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Register writes happen only while the node is idle, so the model takes
  // the new value right away.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_SELF: self_reg = node_t'(data);
      REG_MASK: mask_reg = data[NODES-1:0];
      default: begin
        if (idx <= REG_LINK_3) begin
          link_reg[idx[NODE_W-1:0]] = data;
        end
      end
    endcase
  endtask

  // Offers one word, with random gaps ahead of it, and waits until it is
  // taken. valid stays high afterwards so that words can go back to back.
  task automatic send_word(input command_word_t w, input bit typed, input row_t typed_mins);
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.command       = w.command;
    in_if.peer_node     = w.peer;
    in_if.adv_cost_0    = w.adv[0];
    in_if.adv_cost_1    = w.adv[1];
    in_if.adv_cost_2    = w.adv[2];
    in_if.adv_cost_3    = w.adv[3];
    in_if.new_link_cost = w.new_link;
    do @(posedge clk); while (!in_if.ready);
    apply_command(w, typed, typed_mins);
  endtask

  // Drops valid, waits for every expected word, then lets a word that
  // causes no advertisement finish inside the node.
  task automatic wait_quiet();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (adv_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly small costs so that routes form and change, with a fair share
  // of infinity and of values above it.
  function automatic cost_t random_cost();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return cost_t'($urandom_range(12, 0));
    if (r < 62) return cost_t'(0);
    if (r < 75) return INF_COST;
    if (r < 85) return cost_t'($urandom_range(COST_MAX, INF_COST - 9));
    return cost_t'($urandom_range(COST_MAX, 0));
  endfunction

  function automatic command_word_t random_word();
    command_word_t w;
    int unsigned   r;
    r = $urandom_range(99, 0);
    w.command  = (r < 8) ? CMD_INIT : (r < 58) ? CMD_ADV : (r < 90) ? CMD_LINK : CMD_NONE;
    w.peer     = node_t'($urandom_range(NODES - 1, 0));
    for (int d = 0; d < NODES; d++) begin
      w.adv[d] = random_cost();
    end
    w.new_link = random_cost();
    return w;
  endfunction

  // Phase 0 has every link at zero, phase 1 every link infinite or above;
  // later phases draw link costs, the node id and the mask at random. The
  // mask always names at least one node other than this one.
  task automatic set_phase_config(input int phase);
    cost_t            c;
    node_t            self_id;
    logic [NODES-1:0] mask;
    for (int i = 0; i < NODES; i++) begin
      case (phase)
        0:       c = cost_t'(0);
        1:       c = (i % 2 == 1) ? INF_COST : COST_MAX;
        default: c = ($urandom_range(9, 0) == 0) ? INF_COST : cost_t'($urandom_range(9, 0));
      endcase
      write_reg(CFG_IDX_W'(REG_LINK_0 + i), c);
    end
    case (phase)
      0:       self_id = node_t'(0);
      1:       self_id = node_t'(NODES - 1);
      default: self_id = node_t'($urandom_range(NODES - 1, 0));
    endcase
    if (phase < 2) begin
      mask = '1;
    end else begin
      mask = NODES'($urandom_range(2**NODES - 1, 0));
      mask[(self_id + 1) % NODES] = 1'b1;
    end
    write_reg(REG_SELF, CFG_DATA_W'(self_id));
    write_reg(REG_MASK, CFG_DATA_W'(mask));
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------

  function automatic row_t costs(input cost_t c0, c1, c2, c3);
    row_t r;
    r[0] = c0;
    r[1] = c1;
    r[2] = c2;
    r[3] = c3;
    return r;
  endfunction

  function automatic void plan_typed(input logic [CMD_W-1:0] cmd, input node_t peer,
                                     input row_t adv, input cost_t new_link,
                                     input bit typed, input row_t mins);
    plan_row_t p;
    p.is_write        = 1'b0;
    p.word.command    = cmd;
    p.word.peer       = peer;
    p.word.adv        = adv;
    p.word.new_link   = new_link;
    p.reg_index       = REG_LINK_0;
    p.reg_data        = '0;
    p.typed           = typed;
    p.typed_mins      = mins;
    directed_plan.push_back(p);
  endfunction

  function automatic void plan_word(input logic [CMD_W-1:0] cmd, input node_t peer,
                                    input row_t adv, input cost_t new_link);
    plan_typed(cmd, peer, adv, new_link, 1'b0, '0);
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    plan_row_t p;
    p = '{default: '0};
    p.is_write  = 1'b1;
    p.reg_index = idx;
    p.reg_data  = data;
    directed_plan.push_back(p);
  endfunction

  // The first rows run on the reset configuration: links 1, 0, 1 and
  // infinity, this node is node 1 and it advertises to nodes 0 and 2.
  function automatic void build_directed_plan();
    row_t zeros;
    zeros = costs(0, 0, 0, 0);
    // Init after reset: the minima are the link costs themselves.
    plan_typed(CMD_INIT, 0, zeros, 0, 1'b1, costs(1, 0, 1, INF_COST));
    plan_word(CMD_ADV, 0, costs(0, INF_COST, 5, 3), 0);
    // A neighbor that reaches nothing turns its whole column infinite.
    plan_word(CMD_ADV, 2, costs(INF_COST, INF_COST, INF_COST, INF_COST), 0);
    // No link to node 3, so its offer is worthless.
    plan_word(CMD_ADV, 3, zeros, 0);
    // Sums that reach infinity, and offers above it.
    plan_word(CMD_ADV, 0, costs(COST_MAX, COST_MAX, 998, 0), 0);
    // The peer is this node itself.
    plan_word(CMD_ADV, 1, costs(2, 0, 3, 4), 0);
    // Link to node 0 goes down, comes back free, then carries a column with
    // entries below its own diagonal before it moves again.
    plan_word(CMD_LINK, 0, zeros, INF_COST);
    plan_word(CMD_LINK, 0, zeros, 0);
    plan_word(CMD_ADV, 0, costs(5, 0, 0, 0), 0);
    plan_word(CMD_LINK, 0, zeros, 20);
    plan_word(CMD_LINK, 0, zeros, COST_MAX);
    plan_word(CMD_LINK, 2, zeros, 7);
    // The unused code must change nothing.
    plan_word(CMD_NONE, 3, costs(COST_MAX, COST_MAX, COST_MAX, COST_MAX), COST_MAX);
    // Node 0 as this node, advertising to all three others.
    plan_write(REG_LINK_0, COST_MAX);
    plan_write(REG_LINK_3, 0);
    plan_write(REG_SELF, 0);
    plan_write(REG_MASK, 15);
    plan_typed(CMD_INIT, 0, zeros, 0, 1'b1, costs(INF_COST, 0, 1, 0));
    plan_word(CMD_ADV, 3, costs(1, 1, 1, 0), 0);
    // An empty mask and a mask that names only this node send nothing.
    plan_write(REG_SELF, 3);
    plan_write(REG_MASK, 0);
    plan_word(CMD_INIT, 1, zeros, 0);
    plan_word(CMD_ADV, 2, zeros, 0);
    plan_write(REG_MASK, 8);
    plan_word(CMD_LINK, 1, zeros, 5);
    // Upper data bits of the mask write are don't-care; nodes 1 and 3 remain.
    plan_write(REG_MASK, CFG_DATA_W'(10'h3FA));
    plan_word(CMD_LINK, 1, zeros, 0);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Every word taken from the node is matched against the oldest word still
  // expected, field by field.
  always @(posedge clk) begin : advert_check
    advert_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (adv_expected.size() == 0) begin
        note_failure($sformatf("unexpected word: dest %0d costs %0d %0d %0d %0d last %0b",
                               out_if.dest_node, out_if.min_cost_0, out_if.min_cost_1,
                               out_if.min_cost_2, out_if.min_cost_3, out_if.last));
      end else begin
        want = adv_expected.pop_front();
        if (out_if.dest_node !== want.dest || out_if.min_cost_0 !== want.mins[0] ||
            out_if.min_cost_1 !== want.mins[1] || out_if.min_cost_2 !== want.mins[2] ||
            out_if.min_cost_3 !== want.mins[3] || out_if.last !== want.last) begin
          note_failure($sformatf(
            "word mismatch: expected dest %0d costs %0d %0d %0d %0d last %0b, got %0d %0d %0d %0d %0d %0b",
            want.dest, want.mins[0], want.mins[1], want.mins[2], want.mins[3], want.last,
            out_if.dest_node, out_if.min_cost_0, out_if.min_cost_1, out_if.min_cost_2,
            out_if.min_cost_3, out_if.last));
        end
      end
    end
  end

  // The run ends if nothing moves on either channel or the register port for
  // far longer than the slowest correct run would ever sit still.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d words still expected",
               $realtime, STALL_LIMIT, adv_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: takes words with random gaps, and on request refuses them for
  // a long stretch so that the node fills up and stalls its input side.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left     = 0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    command_word_t w;
    // Every input of the node is known from time zero.
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_LINK_0;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.command       = CMD_INIT;
    in_if.peer_node     = '0;
    in_if.adv_cost_0    = '0;
    in_if.adv_cost_1    = '0;
    in_if.adv_cost_2    = '0;
    in_if.adv_cost_3    = '0;
    in_if.new_link_cost = '0;

    // Model state after reset: every cost infinite, registers at reset value.
    for (int d = 0; d < NODES; d++) begin
      best_vec[d] = INF_COST;
      link_reg[d] = LINK_RESET[d];
      for (int v = 0; v < NODES; v++) begin
        route_table[d][v] = INF_COST;
      end
    end
    self_reg = SELF_RESET;
    mask_reg = MASK_RESET;
    build_directed_plan();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. A group of register writes is preceded by a wait until
    // the node has gone idle.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        if (i == 0 || !directed_plan[i-1].is_write) begin
          wait_quiet();
        end
        write_reg(directed_plan[i].reg_index, directed_plan[i].reg_data);
      end else begin
        send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].typed_mins);
      end
    end

    // Random phases. The first two let the sender idle rarely and the
    // receiver often, the next two the other way round, the last two run
    // flat out. Each phase starts from a fresh configuration and an init so
    // that advertisements and link changes act on a live table.
    for (int phase = 0; phase < PHASES; phase++) begin
      tx_idle_pct = (phase < 2) ? 13 : (phase < 4) ? 86 : 0;
      rx_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 13 : 0;
      wait_quiet();
      set_phase_config(phase);
      w = random_word();
      w.command = CMD_INIT;
      send_word(w, 1'b0, '0);
      if (phase == PHASES - 1) begin
        hold_request = HOLD_CYCLES;
      end
      repeat (WORDS_PER_PHASE) begin
        send_word(random_word(), 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && adv_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
